/* hdl/twc_pkg.sv */
// Shared types and constants of the trie word counter.
// Depends on nothing; every other file of the block but twc_ram imports it.
package twc_pkg;

  localparam int NODE_COUNT   = 4096;
  localparam int NODE_BITS    = $clog2(NODE_COUNT);
  localparam int COUNT_BITS   = 16;
  localparam int ALPHA        = 52;
  localparam int HALF_ALPHA   = 26;
  localparam int SYM_BITS     = $clog2(ALPHA);
  localparam int LINK_DEPTH   = NODE_COUNT * ALPHA;
  localparam int LINK_AW      = $clog2(LINK_DEPTH);
  localparam int OPCODE_W     = 2;
  localparam int LETTER_W     = 8;
  localparam int WORD_COUNT_W = 16;
  localparam int STATUS_W     = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [LETTER_W-1:0] CHAR_A_UPPER = 8'h41;
  localparam logic [LETTER_W-1:0] CHAR_Z_UPPER = 8'h5A;
  localparam logic [LETTER_W-1:0] CHAR_A_LOWER = 8'h61;
  localparam logic [LETTER_W-1:0] CHAR_Z_LOWER = 8'h7A;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POOL_FULL  = 2'd1,
    ST_NON_LETTER = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_ALLOC,
    BK_COUNT,
    BK_RESULT
  } back_state_e;

  typedef logic [ALPHA-1:0] present_t;

  // One classified letter as it travels through the queue.
  typedef struct packed {
    opcode_e               op;
    logic                  is_letter;
    logic [SYM_BITS-1:0]   sym;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* hdl/twc_if.sv */
// Handshake channels of the trie word counter: letters in, word results out.
// Depends on twc_pkg for the field widths.
interface twc_in_if;
  import twc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LETTER_W-1:0] letter;
  logic                word_end;
  modport source (output valid, output opcode, output letter, output word_end, input ready);
  modport sink (input valid, input opcode, input letter, input word_end, output ready);
endinterface

interface twc_out_if;
  import twc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [WORD_COUNT_W-1:0] word_count;
  logic [STATUS_W-1:0]     status;
  modport source (output valid, output word_count, output status, input ready);
  modport sink (input valid, input word_count, input status, output ready);
endinterface

/* hdl/twc_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Self-contained; used for every table of the trie.
module twc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/twc_front.sv */
// Front end: takes letter beats, maps ASCII to the 52-symbol alphabet and
// drops unused opcodes. Depends on twc_pkg and twc_if.
module twc_front (
  twc_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output twc_pkg::item_t  item_o
);
  import twc_pkg::*;

  opcode_e op;

  always_comb begin
    op = opcode_e'(in_i.opcode);
    item_o.op        = op;
    item_o.last      = in_i.word_end;
    item_o.is_letter = 1'b1;
    item_o.sym       = '0;
    if (in_i.letter >= CHAR_A_UPPER && in_i.letter <= CHAR_Z_UPPER) begin
      item_o.sym = SYM_BITS'(in_i.letter - CHAR_A_UPPER);
    end else if (in_i.letter >= CHAR_A_LOWER && in_i.letter <= CHAR_Z_LOWER) begin
      item_o.sym = SYM_BITS'(in_i.letter - CHAR_A_LOWER) + SYM_BITS'(HALF_ALPHA);
    end else begin
      item_o.is_letter = 1'b0;
    end
  end

  // The unused opcode is accepted and then forgotten.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && (op != OP_NONE);

endmodule

/* hdl/twc_queue.sv */
// Short queue of classified letters between the front and back ends.
// Depends on twc_pkg.
module twc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  twc_pkg::item_t   item_i,
  output logic             full_o,
  input  logic             pop_i,
  output twc_pkg::q_head_t head_o
);
  import twc_pkg::*;

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              do_pop;

  assign full_o       = fill_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_o.valid = fill_q != '0;
  assign head_o.item  = slot_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hdl/twc_back.sv */
// Back end: walks the trie one letter at a time, allocates nodes, keeps the
// word counts and drives the result register. Depends on twc_pkg, twc_if, twc_ram.
module twc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  twc_pkg::q_head_t head_i,
  output logic             pop_o,
  twc_out_if.source        out_o
);
  import twc_pkg::*;

  back_state_e state_q, state_d;

  logic [NODE_BITS-1:0]    cur_q, cur_d;
  logic [NODE_BITS-1:0]    free_q, free_d;
  logic                    failed_q, failed_d;
  status_e                 err_q, err_d;
  present_t                root_q, root_d;
  opcode_e                 op_q, op_d;
  logic [SYM_BITS-1:0]     sym_q, sym_d;
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic [WORD_COUNT_W-1:0] out_count_q, out_count_d;
  status_e                 out_status_q, out_status_d;

  logic [SYM_BITS-1:0]     sym_sel;
  logic [LINK_AW-1:0]      link_addr;
  logic                    link_we;
  logic [NODE_BITS-1:0]    link_rd;
  logic                    pres_we;
  present_t                pres_wdata;
  present_t                pres_rd;
  logic                    cnt_we;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic [COUNT_BITS-1:0]   cnt_rd;

  present_t                pdata;
  present_t                mask;
  logic                    hit;
  logic                    pool_full;
  logic                    slot_free;
  logic [NODE_BITS-1:0]    fresh;

  // The root's child set lives in flip-flops so that reset and clear empty
  // the whole trie at once; other nodes are cleared as they are allocated.
  assign pdata     = (cur_q == '0) ? root_q : pres_rd;
  assign mask      = present_t'(1) << sym_q;
  assign hit       = pdata[sym_q];
  assign pool_full = free_q == NODE_BITS'(NODE_COUNT - 1);
  assign fresh     = free_q + 1'b1;
  assign slot_free = !out_valid_q || out_o.ready;

  assign sym_sel   = (state_q == BK_IDLE) ? head_i.item.sym : sym_q;
  assign link_addr = LINK_AW'(cur_q) * LINK_AW'(ALPHA) + LINK_AW'(sym_sel);

  twc_ram #(.WIDTH(NODE_BITS), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_addr),
    .wdata_i (fresh),
    .raddr_i (link_addr),
    .rdata_o (link_rd)
  );

  twc_ram #(.WIDTH(ALPHA), .DEPTH(NODE_COUNT)) u_present_ram (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .waddr_i (cur_q),
    .wdata_i (pres_wdata),
    .raddr_i (cur_q),
    .rdata_o (pres_rd)
  );

  twc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_COUNT)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cur_q),
    .wdata_i (cnt_wdata),
    .raddr_i (cur_q),
    .rdata_o (cnt_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (head_i.valid && head_i.item.op != OP_CLEAR) begin
          if (!head_i.item.is_letter || failed_q) begin
            state_d = head_i.item.last ? BK_RESULT : BK_IDLE;
          end else begin
            state_d = BK_WALK;
          end
        end
      end
      BK_WALK: begin
        if (hit) begin
          state_d = last_q ? BK_COUNT : BK_IDLE;
        end else if (op_q == OP_LOOKUP || pool_full) begin
          state_d = last_q ? BK_RESULT : BK_IDLE;
        end else begin
          state_d = BK_ALLOC;
        end
      end
      BK_ALLOC:  state_d = last_q ? BK_COUNT : BK_IDLE;
      BK_COUNT:  state_d = BK_RESULT;
      BK_RESULT: state_d = slot_free ? BK_IDLE : BK_RESULT;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cur_d        = cur_q;
    free_d       = free_q;
    failed_d     = failed_q;
    err_d        = err_q;
    root_d       = root_q;
    op_d         = op_q;
    sym_d        = sym_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    pop_o        = 1'b0;
    link_we      = 1'b0;
    pres_we      = 1'b0;
    pres_wdata   = '0;
    cnt_we       = 1'b0;
    cnt_wdata    = '0;
    case (state_q)
      BK_IDLE: begin
        pop_o = head_i.valid;
        if (head_i.valid) begin
          op_d   = head_i.item.op;
          sym_d  = head_i.item.sym;
          last_d = head_i.item.last;
          if (head_i.item.op == OP_CLEAR) begin
            root_d   = '0;
            free_d   = '0;
            cur_d    = '0;
            failed_d = 1'b0;
            err_d    = ST_OK;
          end else if (!head_i.item.is_letter) begin
            failed_d = 1'b1;
            if (err_q == ST_OK) begin
              err_d = ST_NON_LETTER;
            end
          end
        end
      end
      BK_WALK: begin
        if (hit) begin
          cur_d = link_rd;
        end else if (op_q == OP_LOOKUP) begin
          failed_d = 1'b1;
        end else if (pool_full) begin
          failed_d = 1'b1;
          err_d    = ST_POOL_FULL;
        end else begin
          free_d  = fresh;
          link_we = 1'b1;
          cur_d   = fresh;
          if (cur_q == '0) begin
            root_d = pdata | mask;
          end else begin
            pres_we    = 1'b1;
            pres_wdata = pdata | mask;
          end
        end
      end
      BK_ALLOC: begin
        // The fresh node starts with no children and a zero count.
        pres_we = 1'b1;
        cnt_we  = 1'b1;
      end
      BK_RESULT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_count_d  = '0;
          out_status_d = ST_OK;
          if (failed_q) begin
            out_status_d = err_q;
          end else begin
            out_count_d = WORD_COUNT_W'(cnt_rd);
            if (op_q == OP_INSERT) begin
              if (cnt_rd == '1) begin
                out_status_d = ST_SATURATED;
              end else begin
                cnt_we      = 1'b1;
                cnt_wdata   = cnt_rd + 1'b1;
                out_count_d = WORD_COUNT_W'(cnt_wdata);
              end
            end
          end
          cur_d    = '0;
          failed_d = 1'b0;
          err_d    = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cur_q       <= '0;
      free_q      <= '0;
      failed_q    <= 1'b0;
      err_q       <= ST_OK;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      failed_q    <= failed_d;
      err_q       <= err_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    sym_q        <= sym_d;
    last_q       <= last_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.word_count = out_count_q;
  assign out_o.status     = out_status_q;

endmodule

/* hdl/trie_word_counter_top.sv */
// Trie word counter. A letter beat enters a two-entry queue and then passes
// the back end's idle and walk states (and alloc when a node is allocated;
// a non-letter or a letter after the walk has failed is handled in idle); the child
// table read feeds the next letter's address. A word's last letter then passes
// count (count read) and result (update), or result alone if the walk failed.
// Reset is asynchronous and empties the trie at once, with no clearing sweep.
module trie_word_counter_top (
  input logic        clk_i,
  input logic        rst_ni,
  twc_in_if.sink     in_i,
  twc_out_if.source  out_o
);
  import twc_pkg::*;

  logic    push;
  logic    full;
  logic    pop;
  item_t   item;
  q_head_t head;

  twc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (item)
  );

  twc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  twc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench of the trie word counter: sends letter beats, keeps
// its own trie to predict each word result, and checks the result channel.
// Depends on twc_pkg, the twc_in_if/twc_out_if channels and trie_word_counter_top.
module testbench;
  import twc_pkg::*;

  typedef struct packed {
    logic [WORD_COUNT_W-1:0] count;
    status_e                 status;
  } word_result_t;

  typedef struct {
    logic [LETTER_W-1:0] ch [16];
    int unsigned         len;
  } word_t;

  class trie_scoreboard;
    logic [NODE_BITS-1:0]  link_tbl [LINK_DEPTH];
    present_t              present_tbl [NODE_COUNT];
    logic [COUNT_BITS-1:0] count_tbl [NODE_COUNT];
    int unsigned           last_taken;
    int unsigned           walk_node;
    bit                    walk_lost;
    status_e               word_status;
    word_result_t          expected_words [$];
    int unsigned           checked;
    int unsigned           mismatches;
    int unsigned           pool_full_seen;
    int unsigned           saturated_seen;

    function new();
      foreach (present_tbl[i]) present_tbl[i] = '0;
      last_taken = 0;
      restart_walk();
    endfunction

    function int letter_symbol(logic [LETTER_W-1:0] ch);
      if (ch >= CHAR_A_UPPER && ch <= CHAR_Z_UPPER) return int'(ch - CHAR_A_UPPER);
      if (ch >= CHAR_A_LOWER && ch <= CHAR_Z_LOWER)
        return HALF_ALPHA + int'(ch - CHAR_A_LOWER);
      return -1;
    endfunction

    function void restart_walk();
      walk_node = 0;
      walk_lost = 1'b0;
      word_status = ST_OK;
    endfunction

    // A missed lookup leaves the error code at zero, so a later non-letter
    // in the same word still gets recorded.
    function void fail_walk(status_e code);
      walk_lost = 1'b1;
      if (word_status == ST_OK) word_status = code;
    endfunction

    function void note_input(opcode_e op, logic [LETTER_W-1:0] ch, logic last);
      int           sym;
      int unsigned  idx;
      word_result_t res;
      sym = letter_symbol(ch);
      if (op == OP_NONE) return;
      if (op == OP_CLEAR) begin
        // Emptying the root is enough: every node taken later starts blank.
        present_tbl[0] = '0;
        last_taken = 0;
        restart_walk();
        return;
      end
      if (!walk_lost) begin
        if (sym < 0) begin
          fail_walk(ST_NON_LETTER);
        end else begin
          idx = walk_node * ALPHA + sym;
          if (present_tbl[walk_node][sym]) begin
            walk_node = link_tbl[idx];
          end else if (op == OP_LOOKUP) begin
            fail_walk(ST_OK);
          end else if (last_taken + 1 >= NODE_COUNT) begin
            fail_walk(ST_POOL_FULL);
          end else begin
            last_taken++;
            present_tbl[last_taken] = '0;
            count_tbl[last_taken] = '0;
            link_tbl[idx] = NODE_BITS'(last_taken);
            present_tbl[walk_node][sym] = 1'b1;
            walk_node = last_taken;
          end
        end
      end else if (sym < 0) begin
        fail_walk(ST_NON_LETTER);
      end
      if (!last) return;
      res.count = '0;
      res.status = word_status;
      if (!walk_lost) begin
        res.count = count_tbl[walk_node];
        if (op == OP_INSERT) begin
          if (&res.count) begin
            res.status = ST_SATURATED;
          end else begin
            res.count = res.count + 1'b1;
            count_tbl[walk_node] = res.count;
          end
        end
      end
      expected_words.push_back(res);
      restart_walk();
    endfunction

    function void check_result(logic [WORD_COUNT_W-1:0] count, logic [STATUS_W-1:0] status);
      word_result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result with nothing expected: word_count %0d, status %0d",
                 $time, count, status);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (want.status == ST_POOL_FULL) pool_full_seen++;
      if (want.status == ST_SATURATED) saturated_seen++;
      if (count !== want.count) begin
        $display("%0t: word_count mismatch: expected %0d, actual %0d",
                 $time, want.count, count);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  twc_in_if  in_if ();
  twc_out_if out_if ();

  trie_word_counter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  trie_scoreboard words_board = new();
  word_t          word_bank [$];
  int             gap_pct = 0;
  int             stall_pct = 0;
  int             hold_request = 0;
  int unsigned    beats_sent = 0;
  int unsigned    words_sent = 0;
  int unsigned    clears_sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Ends a hung run; far above a full run at its slowest.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: checks every beat and stalls at random or for a long hold.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        words_board.check_result(out_if.word_count, out_if.status);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [LETTER_W-1:0] symbol_char(int k);
    if (k < HALF_ALPHA) return CHAR_A_UPPER + LETTER_W'(k);
    return CHAR_A_LOWER + LETTER_W'(k - HALF_ALPHA);
  endfunction

  function automatic logic [LETTER_W-1:0] random_non_letter();
    logic [LETTER_W-1:0] b;
    do b = LETTER_W'($urandom_range(255));
    while (words_board.letter_symbol(b) >= 0);
    return b;
  endfunction

  function automatic word_t word_of(string s);
    word_t w;
    w.len = s.len();
    for (int i = 0; i < s.len(); i++) w.ch[i] = s[i];
    return w;
  endfunction

  function automatic word_t random_word(int lo, int hi);
    word_t w;
    w.len = $urandom_range(hi, lo);
    for (int i = 0; i < w.len; i++) w.ch[i] = symbol_char($urandom_range(ALPHA - 1));
    return w;
  endfunction

  // A stored word cut back to a prefix and given a short random tail, so
  // new words share paths with old ones.
  function automatic word_t grown_word();
    word_t w;
    if (word_bank.size() == 0) return random_word(1, 6);
    w = word_bank[$urandom_range(word_bank.size() - 1)];
    w.len = $urandom_range(w.len, 1);
    repeat ($urandom_range(3)) begin
      if (w.len < 16) begin
        w.ch[w.len] = symbol_char($urandom_range(ALPHA - 1));
        w.len++;
      end
    end
    return w;
  endfunction

  function automatic void remember_word(word_t w);
    if (word_bank.size() < 48) word_bank.push_back(w);
    else word_bank[$urandom_range(47)] = w;
  endfunction

  task automatic send_beat(opcode_e op, logic [LETTER_W-1:0] ch, logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.letter   <= ch;
    in_if.word_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    words_board.note_input(op, ch, last);
    if (op != OP_NONE) beats_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  task automatic send_word(word_t w, opcode_e last_op, bit mixed);
    opcode_e op;
    for (int i = 0; i < w.len; i++) begin
      op = last_op;
      if (mixed && i + 1 < w.len) op = opcode_e'($urandom_range(1));
      send_beat(op, w.ch[i], i + 1 == w.len);
    end
    words_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int gap, int stall, int beats_target, bit squeeze);
    int unsigned start;
    int unsigned pick;
    int unsigned keep;
    word_t       w;
    gap_pct = gap;
    stall_pct = stall;
    start = beats_sent;
    if (squeeze) begin
      // Short words back to back against a held result side fill the block.
      hold_request = 400;
      repeat (40) send_word(random_word(1, 1), OP_INSERT, 1'b0);
    end
    while (beats_sent - start < beats_target) begin
      pick = $urandom_range(99);
      if (pick < 30 && word_bank.size() != 0) begin
        send_word(word_bank[$urandom_range(word_bank.size() - 1)], OP_INSERT, 1'b0);
      end else if (pick < 45) begin
        w = grown_word();
        remember_word(w);
        send_word(w, OP_INSERT, 1'b0);
      end else if (pick < 65) begin
        send_word(grown_word(), OP_LOOKUP, 1'b0);
      end else if (pick < 73) begin
        send_word(random_word(1, 4), OP_LOOKUP, 1'b0);
      end else if (pick < 81) begin
        send_word(grown_word(), opcode_e'($urandom_range(1)), 1'b1);
      end else if (pick < 89) begin
        w = grown_word();
        w.ch[$urandom_range(w.len - 1)] = random_non_letter();
        send_word(w, opcode_e'($urandom_range(1)), 1'b0);
      end else if (pick < 92) begin
        w = grown_word();
        keep = $urandom_range(w.len);
        for (int i = 0; i < keep; i++)
          send_beat(opcode_e'($urandom_range(1)), w.ch[i], 1'b0);
        send_beat(OP_CLEAR, LETTER_W'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 93) begin
        send_beat(OP_CLEAR, LETTER_W'($urandom_range(255)), 1'b0);
      end else if (pick < 97) begin
        send_beat(OP_NONE, LETTER_W'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        w = random_word(10, 16);
        remember_word(w);
        send_word(w, OP_INSERT, 1'b0);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.opcode   <= OP_INSERT;
    in_if.letter   <= '0;
    in_if.word_end <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on a fresh store.
    send_word(word_of("A"), OP_LOOKUP, 1'b0);
    send_word(word_of("A"), OP_INSERT, 1'b0);
    send_word(word_of("z"), OP_INSERT, 1'b0);
    send_word(word_of("Az"), OP_INSERT, 1'b0);
    send_word(word_of("Az"), OP_LOOKUP, 1'b0);
    send_word(word_of("A"), OP_INSERT, 1'b0);
    send_word(word_of("Zq"), OP_LOOKUP, 1'b0);
    send_word(word_of("b@"), OP_INSERT, 1'b0);
    send_beat(OP_LOOKUP, 8'h00, 1'b0);
    send_beat(OP_INSERT, 8'hFF, 1'b1);
    send_word(word_of("Qx["), OP_LOOKUP, 1'b0);
    send_beat(OP_LOOKUP, "A", 1'b0);
    send_beat(OP_INSERT, "z", 1'b1);
    send_beat(OP_INSERT, "a", 1'b0);
    send_beat(OP_LOOKUP, "n", 1'b1);
    send_word(word_of("`{"), OP_INSERT, 1'b0);
    send_beat(OP_INSERT, "Y", 1'b0);
    send_beat(OP_CLEAR, "Y", 1'b1);
    send_beat(OP_NONE, 8'hA5, 1'b1);
    send_word(word_of("A"), OP_LOOKUP, 1'b0);
    wait_drained();

    random_phase(0, 0, 350, 1'b1);
    random_phase(85, 0, 350, 1'b0);
    random_phase(0, 85, 350, 1'b0);
    random_phase(36, 36, 350, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d letter beats in %0d words with %0d store clears; checked %0d results.",
             beats_sent, words_sent, clears_sent, words_board.checked);
    $display("Words answered with a full pool: %0d, with a saturated count: %0d.",
             words_board.pool_full_seen, words_board.saturated_seen);
    if (words_board.mismatches == 0 && words_board.expected_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
